// File: sv/ldr_pkg.sv
// ----------------------------------------------------------------------------
// ldr_pkg: shared types and constants of the dice roller
// Request kinds, controller states, the command and status groups between the
// controller and the datapath, and the arithmetic constants of the generator.
// ----------------------------------------------------------------------------
package ldr_pkg;

  localparam int unsigned LDR_MAX_DICE       = 255;
  localparam int unsigned LDR_MAX_SIDES      = 100;
  localparam int unsigned LDR_DRAW_LIMIT     = 65520;
  localparam int unsigned LDR_INCR_MULT      = 2401;
  localparam int unsigned LDR_MULT_WHEEL_RST = 11939;
  localparam int unsigned LDR_INCR_WHEEL_RST = 19937;
  localparam int unsigned LDR_WHEEL_SPAN     = 10000;
  localparam int unsigned LDR_TOTAL_MAX      = 25500;
  localparam int unsigned LDR_PCT_ZERO       = 100;
  localparam int unsigned LDR_WHEEL_DIGITS   = 5;
  localparam int unsigned LDR_DIV10_MUL      = 104858;
  localparam int unsigned LDR_DIV10_SHIFT    = 20;

  localparam int unsigned LDR_STATE_W = 32;
  localparam int unsigned LDR_WHEEL_W = 17;
  localparam int unsigned LDR_COUNT_W = 8;
  localparam int unsigned LDR_SIDES_W = 7;
  localparam int unsigned LDR_TOTAL_W = 15;
  localparam int unsigned LDR_DRAW_W  = 16;

  typedef enum logic [1:0] {
    KIND_ROLL  = 2'd0,
    KIND_FLIP  = 2'd1,
    KIND_PCT   = 2'd2,
    KIND_SHAKE = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_ADD,
    ST_DIV,
    ST_ACC,
    ST_MOD_DIV,
    ST_SAVE,
    ST_SPIN_CHK,
    ST_SPIN_A,
    ST_SPIN_B,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic add;
    logic div_step;
    logic acc;
    logic mod_start;
    logic save_ra;
    logic save_rc;
    logic spin_a;
    logic spin_b;
    logic finish;
  } ldr_cmd_t;

  typedef struct packed {
    logic dice_zero;
    logic reject;
    logic div_last;
    logic is_shake;
    logic spin_any;
  } ldr_status_t;

endpackage

// File: sv/ldr_ctrl.sv
// ----------------------------------------------------------------------------
// ldr_ctrl: request sequencer of the dice roller
// Steps the datapath through draws, redraws, remainders, sums and wheel
// rotations for one request at a time.
// ----------------------------------------------------------------------------
module ldr_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ldr_pkg::ldr_status_t status,
  output ldr_pkg::ldr_cmd_t    cmd
);

  ldr_pkg::state_t state_r, state_nxt;
  logic            phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ldr_pkg::ST_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    busy      = (state_r != ldr_pkg::ST_IDLE);
    unique case (state_r)
      ldr_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          phase_nxt = 1'b0;
          state_nxt = ldr_pkg::ST_CHECK;
        end
      end
      ldr_pkg::ST_CHECK: begin
        if (!status.dice_zero) begin
          state_nxt = ldr_pkg::ST_MUL;
        end else if (status.is_shake) begin
          cmd.mod_start = 1'b1;
          state_nxt     = ldr_pkg::ST_MOD_DIV;
        end else begin
          state_nxt = ldr_pkg::ST_FIN;
        end
      end
      ldr_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ldr_pkg::ST_ADD;
      end
      ldr_pkg::ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = status.reject ? ldr_pkg::ST_MUL : ldr_pkg::ST_DIV;
      end
      ldr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ldr_pkg::ST_ACC;
        end
      end
      ldr_pkg::ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = ldr_pkg::ST_CHECK;
      end
      ldr_pkg::ST_MOD_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = ldr_pkg::ST_SAVE;
        end
      end
      ldr_pkg::ST_SAVE: begin
        if (!phase_r) begin
          cmd.save_ra = 1'b1;
          phase_nxt   = 1'b1;
          state_nxt   = ldr_pkg::ST_CHECK;
        end else begin
          cmd.save_rc = 1'b1;
          state_nxt   = ldr_pkg::ST_SPIN_CHK;
        end
      end
      ldr_pkg::ST_SPIN_CHK: begin
        state_nxt = status.spin_any ? ldr_pkg::ST_SPIN_A : ldr_pkg::ST_FIN;
      end
      ldr_pkg::ST_SPIN_A: begin
        cmd.spin_a = 1'b1;
        state_nxt  = ldr_pkg::ST_SPIN_B;
      end
      ldr_pkg::ST_SPIN_B: begin
        cmd.spin_b = 1'b1;
        state_nxt  = ldr_pkg::ST_SPIN_CHK;
      end
      ldr_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ldr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = ldr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/ldr_datapath.sv
// ----------------------------------------------------------------------------
// ldr_datapath: generator, remainder unit and accumulator of the dice roller
// Holds the generator state and both wheels, runs a bit-serial remainder
// unit, sums faces with saturation and drives the result registers.
// ----------------------------------------------------------------------------
module ldr_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ldr_pkg::ldr_cmd_t                   cmd,
  output ldr_pkg::ldr_status_t                status,
  input  logic                                seed_we,
  input  logic [ldr_pkg::LDR_STATE_W-1:0]     seed_data,
  input  logic [1:0]                          in_kind,
  input  logic [ldr_pkg::LDR_COUNT_W-1:0]     in_count,
  input  logic [ldr_pkg::LDR_SIDES_W-1:0]     in_sides,
  output logic                                out_valid,
  output logic [ldr_pkg::LDR_TOTAL_W-1:0]     out_total
);

  localparam int unsigned SW = ldr_pkg::LDR_STATE_W;
  localparam int unsigned WW = ldr_pkg::LDR_WHEEL_W;
  localparam int unsigned CW = ldr_pkg::LDR_COUNT_W;
  localparam int unsigned FW = ldr_pkg::LDR_SIDES_W;
  localparam int unsigned TW = ldr_pkg::LDR_TOTAL_W;
  localparam int unsigned DW = ldr_pkg::LDR_DRAW_W;
  localparam int unsigned QW = WW - 3;
  localparam int unsigned PW = 2 * WW;

  function automatic logic [WW-1:0] span_of(input logic [3:0] d);
    logic [WW-1:0] v;
    v = '0;
    unique case (d)
      4'd0:    v = WW'(0);
      4'd1:    v = WW'(1 * ldr_pkg::LDR_WHEEL_SPAN);
      4'd2:    v = WW'(2 * ldr_pkg::LDR_WHEEL_SPAN);
      4'd3:    v = WW'(3 * ldr_pkg::LDR_WHEEL_SPAN);
      4'd4:    v = WW'(4 * ldr_pkg::LDR_WHEEL_SPAN);
      4'd5:    v = WW'(5 * ldr_pkg::LDR_WHEEL_SPAN);
      4'd6:    v = WW'(6 * ldr_pkg::LDR_WHEEL_SPAN);
      4'd7:    v = WW'(7 * ldr_pkg::LDR_WHEEL_SPAN);
      4'd8:    v = WW'(8 * ldr_pkg::LDR_WHEEL_SPAN);
      4'd9:    v = WW'(9 * ldr_pkg::LDR_WHEEL_SPAN);
      default: v = '0;
    endcase
    return v;
  endfunction

  logic [SW-1:0]     gen_r, prod_r, inc_r;
  logic [WW-1:0]     mw_r, iw_r, w_r;
  logic [QW-1:0]     q_r;
  logic [CW-1:0]     cnt_r, n_r;
  logic [FW-1:0]     faces_r, div_r, rem_r;
  logic [DW-1:0]     dvd_r;
  logic [3:0]        bit_r;
  logic [TW-1:0]     sum_r;
  logic [2:0]        ra_r, rc_r;
  logic              plus1_r;
  ldr_pkg::kind_t    kind_r;
  logic              out_valid_r;
  logic [TW-1:0]     out_total_r;

  ldr_pkg::kind_t    kind_in;
  logic [CW-1:0]     n_clamp;
  logic [FW-1:0]     sides_fix, sides_clamp;
  logic [SW-1:0]     gen_nxt;
  logic [SW-1:0]     mul_full;
  logic [SW-1:0]     inc_full;
  logic [FW:0]       trial;
  logic [FW-1:0]     rem_nxt;
  logic [TW:0]       face_sum;
  logic [TW-1:0]     acc_nxt;
  logic [PW-1:0]     spin_prod;
  logic [WW-1:0]     w_sel, w_rot;
  logic [3:0]        digit;
  logic [TW-1:0]     fin_total;

  assign kind_in     = ldr_pkg::kind_t'(in_kind);
  assign n_clamp     = (32'(in_count) > ldr_pkg::LDR_MAX_DICE) ?
                       CW'(ldr_pkg::LDR_MAX_DICE) : in_count;
  assign sides_fix   = (in_sides == '0) ? FW'(1) : in_sides;
  assign sides_clamp = (32'(sides_fix) > ldr_pkg::LDR_MAX_SIDES) ?
                       FW'(ldr_pkg::LDR_MAX_SIDES) : sides_fix;

  assign mul_full = gen_r * SW'({mw_r, 2'b01});
  assign inc_full = SW'(iw_r) * SW'(ldr_pkg::LDR_INCR_MULT);
  assign gen_nxt  = prod_r + inc_r;

  assign trial   = {rem_r, dvd_r[DW-1]};
  assign rem_nxt = (trial >= {1'b0, div_r}) ? FW'(trial - {1'b0, div_r}) : trial[FW-1:0];

  assign face_sum = (TW+1)'(sum_r) + (TW+1)'(rem_r) + (TW+1)'(plus1_r);
  always_comb begin
    if (kind_r == ldr_pkg::KIND_PCT) begin
      acc_nxt = TW'(sum_r * TW'(10)) + TW'(rem_r);
    end else if (face_sum > (TW+1)'(ldr_pkg::LDR_TOTAL_MAX)) begin
      acc_nxt = TW'(ldr_pkg::LDR_TOTAL_MAX);
    end else begin
      acc_nxt = face_sum[TW-1:0];
    end
  end

  assign w_sel     = (ra_r != '0) ? mw_r : iw_r;
  assign spin_prod = PW'(w_sel) * PW'(ldr_pkg::LDR_DIV10_MUL);
  assign digit     = 4'(w_r - ({3'b000, q_r, 3'b000} + {2'b00, q_r, 1'b0}));
  assign w_rot     = WW'(q_r) + span_of(digit);

  always_comb begin
    unique case (kind_r)
      ldr_pkg::KIND_SHAKE: fin_total = '0;
      ldr_pkg::KIND_PCT:   fin_total = (sum_r == '0) ? TW'(ldr_pkg::LDR_PCT_ZERO) : sum_r;
      default:             fin_total = sum_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r       <= '0;
      mw_r        <= WW'(ldr_pkg::LDR_MULT_WHEEL_RST);
      iw_r        <= WW'(ldr_pkg::LDR_INCR_WHEEL_RST);
      cnt_r       <= '0;
      bit_r       <= '0;
      ra_r        <= '0;
      rc_r        <= '0;
      kind_r      <= ldr_pkg::KIND_ROLL;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (seed_we) begin
        gen_r <= seed_data;
      end else if (cmd.add) begin
        gen_r <= gen_nxt;
      end
      if (cmd.load) begin
        kind_r <= kind_in;
        bit_r  <= '0;
        unique case (kind_in)
          ldr_pkg::KIND_PCT: cnt_r <= CW'(2);
          default:           cnt_r <= n_clamp;
        endcase
      end else if (cmd.acc) begin
        cnt_r <= cnt_r - CW'(1);
      end else if (cmd.save_ra) begin
        cnt_r <= n_r;
      end
      if (cmd.add || cmd.mod_start) begin
        bit_r <= '0;
      end else if (cmd.div_step) begin
        bit_r <= bit_r + 4'd1;
      end
      if (cmd.save_ra) begin
        ra_r <= 3'(rem_r);
      end else if (cmd.spin_b && (ra_r != '0)) begin
        ra_r <= ra_r - 3'd1;
      end
      if (cmd.save_rc) begin
        rc_r <= 3'(rem_r);
      end else if (cmd.spin_b && (ra_r == '0)) begin
        rc_r <= rc_r - 3'd1;
      end
      if (cmd.spin_b) begin
        if (ra_r != '0) begin
          mw_r <= w_rot;
        end else begin
          iw_r <= w_rot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r   <= n_clamp;
      sum_r <= '0;
      unique case (kind_in)
        ldr_pkg::KIND_ROLL: begin
          faces_r <= sides_clamp;
          plus1_r <= (sides_clamp != FW'(10));
        end
        ldr_pkg::KIND_FLIP: begin
          faces_r <= FW'(2);
          plus1_r <= 1'b0;
        end
        ldr_pkg::KIND_PCT: begin
          faces_r <= FW'(10);
          plus1_r <= 1'b0;
        end
        default: begin
          faces_r <= FW'(4);
          plus1_r <= 1'b1;
        end
      endcase
    end
    if (cmd.mul) begin
      prod_r <= mul_full;
      inc_r  <= inc_full;
    end
    if (cmd.add) begin
      dvd_r <= gen_nxt[SW-1 -: DW];
      rem_r <= '0;
      div_r <= faces_r;
    end else if (cmd.mod_start) begin
      dvd_r <= DW'(sum_r);
      rem_r <= '0;
      div_r <= FW'(ldr_pkg::LDR_WHEEL_DIGITS);
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
    if (cmd.acc) begin
      sum_r <= acc_nxt;
    end else if (cmd.save_ra) begin
      sum_r <= '0;
    end
    if (cmd.spin_a) begin
      q_r <= spin_prod[ldr_pkg::LDR_DIV10_SHIFT +: QW];
      w_r <= w_sel;
    end
    if (cmd.finish) begin
      out_total_r <= fin_total;
    end
  end

  assign status.dice_zero = (cnt_r == '0);
  assign status.reject    = (gen_nxt[SW-1 -: DW] > DW'(ldr_pkg::LDR_DRAW_LIMIT));
  assign status.div_last  = (bit_r == 4'd15);
  assign status.is_shake  = (kind_r == ldr_pkg::KIND_SHAKE);
  assign status.spin_any  = (ra_r != '0) || (rc_r != '0);

  assign out_valid = out_valid_r;
  assign out_total = out_total_r;

endmodule

// File: sv/lcg_dice_roller.sv
// ----------------------------------------------------------------------------
// lcg_dice_roller: dice, coin and percentile generator on a 32-bit LCG
// Top level: configuration register, sequencer and datapath.
// ----------------------------------------------------------------------------
// A request (in_kind, in_count, in_sides) is taken on a clock edge with start
// high and busy low. busy stays high until the request is finished. The result
// shows on out_total, marked by out_valid for exactly one cycle, in the cycle
// in which busy falls; out_total holds it until the next result. The receiver
// cannot stall it, so nothing waits on it. Each die or coin takes a multiply
// and an add for the generator step, the bit-serial remainder unit, one
// accumulate and one check; every rejected draw repeats the multiply and add.
// A percentile roll counts two dice. A shake runs the two rolls and the two
// mod-5 remainders, then each wheel rotation through ST_SPIN_CHK, ST_SPIN_A
// and ST_SPIN_B. The seed register answers at addresses 0 to 3 of the APB
// port (paddr[2] low); writing it loads the generator state. The user must
// ensure writes are made only while busy is low; the block does not enforce it.
// Reset clears the generator state and the seed to zero and loads both wheels
// with their start values; no request is pending after reset.
// ----------------------------------------------------------------------------
module lcg_dice_roller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_kind,
  input  logic [ldr_pkg::LDR_COUNT_W-1:0] in_count,
  input  logic [ldr_pkg::LDR_SIDES_W-1:0] in_sides,
  output logic                            out_valid,
  output logic [ldr_pkg::LDR_TOTAL_W-1:0] out_total
);

  logic [31:0]          seed_r;
  logic                 seed_we;
  ldr_pkg::ldr_cmd_t    cmd;
  ldr_pkg::ldr_status_t status;

  assign pready  = 1'b1;
  assign seed_we = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata  = (paddr[2] == 1'b0) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (seed_we) begin
      seed_r <= pwdata;
    end
  end

  ldr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  ldr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .seed_we   (seed_we),
    .seed_data (pwdata),
    .in_kind   (in_kind),
    .in_count  (in_count),
    .in_sides  (in_sides),
    .out_valid (out_valid),
    .out_total (out_total)
  );

endmodule

// File: sim/tb_lcg_dice_roller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcg_dice_roller: self-checking testbench of the dice roller
// Requests go in through the start/busy handshake and every total is checked
// against a known value or a predictor that models the generator, its two
// wheels and the seed. A table of directed requests comes first. Random requests
// under several seeds follow, with random gaps and one stretch without any gaps.
// ----------------------------------------------------------------------------
module tb_lcg_dice_roller;

  localparam int          CYCLE_LIMIT = 20_000_000;
  localparam logic [2:0]  SEED_ADDR   = 3'd0;

  typedef struct packed {
    ldr_pkg::kind_t kind;
    logic [7:0]     count;
    logic [6:0]     sides;
    logic           known;
    logic [14:0]    total;
  } dice_req_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [7:0]  in_count;
  logic [6:0]  in_sides;
  logic        out_valid;
  logic [14:0] out_total;

  // Predictor state: generator, wheels, and the totals still owed by the block.
  logic [31:0] lcg_q;
  logic [16:0] mul_wheel_q;
  logic [16:0] inc_wheel_q;
  int unsigned redraws;
  logic [14:0] total_q[$];
  logic [14:0] want_total;
  int          fail_count;
  int          cycle_count;
  bit          steady_stretch;

  dice_req_t directed_reqs [20] = '{
    '{ldr_pkg::KIND_ROLL,  8'd0,   7'd6,   1'b1, 15'd0},
    '{ldr_pkg::KIND_FLIP,  8'd0,   7'd0,   1'b1, 15'd0},
    '{ldr_pkg::KIND_SHAKE, 8'd0,   7'd127, 1'b1, 15'd0},
    '{ldr_pkg::KIND_ROLL,  8'd5,   7'd1,   1'b1, 15'd5},
    '{ldr_pkg::KIND_ROLL,  8'd7,   7'd0,   1'b1, 15'd7},
    '{ldr_pkg::KIND_ROLL,  8'd255, 7'd1,   1'b1, 15'd255},
    '{ldr_pkg::KIND_ROLL,  8'd255, 7'd100, 1'b0, 15'd0},
    '{ldr_pkg::KIND_ROLL,  8'd255, 7'd127, 1'b0, 15'd0},
    '{ldr_pkg::KIND_ROLL,  8'd3,   7'd10,  1'b0, 15'd0},
    '{ldr_pkg::KIND_ROLL,  8'd4,   7'd6,   1'b0, 15'd0},
    '{ldr_pkg::KIND_ROLL,  8'd1,   7'd2,   1'b0, 15'd0},
    '{ldr_pkg::KIND_FLIP,  8'd255, 7'd127, 1'b0, 15'd0},
    '{ldr_pkg::KIND_FLIP,  8'd16,  7'd5,   1'b0, 15'd0},
    '{ldr_pkg::KIND_PCT,   8'd255, 7'd127, 1'b0, 15'd0},
    '{ldr_pkg::KIND_PCT,   8'd0,   7'd0,   1'b0, 15'd0},
    '{ldr_pkg::KIND_SHAKE, 8'd1,   7'd0,   1'b1, 15'd0},
    '{ldr_pkg::KIND_SHAKE, 8'd255, 7'd0,   1'b1, 15'd0},
    '{ldr_pkg::KIND_SHAKE, 8'd13,  7'd42,  1'b1, 15'd0},
    '{ldr_pkg::KIND_ROLL,  8'd9,   7'd100, 1'b0, 15'd0},
    '{ldr_pkg::KIND_ROLL,  8'd2,   7'd64,  1'b0, 15'd0}
  };

  lcg_dice_roller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .start     (start),
    .busy      (busy),
    .in_kind   (in_kind),
    .in_count  (in_count),
    .in_sides  (in_sides),
    .out_valid (out_valid),
    .out_total (out_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned next_draw();
    logic [31:0] mul;
    logic [31:0] inc;
    mul = {13'd0, mul_wheel_q, 2'b01};
    inc = ldr_pkg::LDR_INCR_MULT * {15'd0, inc_wheel_q};
    lcg_q = mul * lcg_q + inc;
    while ({16'd0, lcg_q[31:16]} > ldr_pkg::LDR_DRAW_LIMIT) begin
      redraws++;
      lcg_q = mul * lcg_q + inc;
    end
    return {16'd0, lcg_q[31:16]};
  endfunction

  function automatic int unsigned roll_sum(input int unsigned n, input int unsigned faces);
    int unsigned sum;
    int unsigned face;
    sum = 0;
    if (faces == 0) begin
      faces = 1;
    end
    if (faces > ldr_pkg::LDR_MAX_SIDES) begin
      faces = ldr_pkg::LDR_MAX_SIDES;
    end
    for (int unsigned i = 0; i < n; i++) begin
      face = next_draw() % faces;
      if (faces != 10) begin
        face += 1;
      end
      sum += face;
      if (sum > ldr_pkg::LDR_TOTAL_MAX) begin
        sum = ldr_pkg::LDR_TOTAL_MAX;
      end
    end
    return sum;
  endfunction

  // A rotation moves the last decimal digit of the wheel to the front.
  function automatic logic [16:0] spin_wheel(input logic [16:0] w);
    int unsigned v;
    int unsigned t;
    v = {15'd0, w};
    t = v / 10 + ldr_pkg::LDR_WHEEL_SPAN * (v % 10);
    return t[16:0];
  endfunction

  function automatic logic [14:0] predict_total(input ldr_pkg::kind_t k,
                                                input logic [7:0] c,
                                                input logic [6:0] s);
    int unsigned n;
    int unsigned t;
    int unsigned tens;
    int unsigned ra;
    int unsigned rc;
    n = {24'd0, c};
    if (n > ldr_pkg::LDR_MAX_DICE) begin
      n = ldr_pkg::LDR_MAX_DICE;
    end
    t = 0;
    case (k)
      ldr_pkg::KIND_ROLL: begin
        t = roll_sum(n, {25'd0, s});
      end
      ldr_pkg::KIND_FLIP: begin
        for (int unsigned i = 0; i < n; i++) begin
          t += next_draw() % 2;
          if (t > ldr_pkg::LDR_TOTAL_MAX) begin
            t = ldr_pkg::LDR_TOTAL_MAX;
          end
        end
      end
      ldr_pkg::KIND_PCT: begin
        tens = next_draw() % 10;
        t = tens * 10 + next_draw() % 10;
        if (t == 0) begin
          t = ldr_pkg::LDR_PCT_ZERO;
        end
      end
      default: begin
        ra = roll_sum(n, 4) % ldr_pkg::LDR_WHEEL_DIGITS;
        rc = roll_sum(n, 4) % ldr_pkg::LDR_WHEEL_DIGITS;
        repeat (ra) mul_wheel_q = spin_wheel(mul_wheel_q);
        repeat (rc) inc_wheel_q = spin_wheel(inc_wheel_q);
        t = 0;
      end
    endcase
    return t[14:0];
  endfunction

  // Searches for a seed under which the next request hits a rare case: either
  // the first draw is rejected, or a percentile request comes out as zero.
  function automatic logic [31:0] find_seed(input bit want_pct_zero);
    logic [31:0] saved;
    logic [31:0] cand;
    int unsigned a;
    int unsigned b;
    int unsigned first_rejects;
    bit          hit;
    saved = lcg_q;
    cand  = '0;
    hit   = 1'b0;
    while (!hit) begin
      cand    = $urandom();
      lcg_q   = cand;
      redraws = 0;
      a = next_draw();
      first_rejects = redraws;
      b = next_draw();
      hit = want_pct_zero ? (a % 10 == 0 && b % 10 == 0) : (first_rejects != 0);
    end
    lcg_q = saved;
    return cand;
  endfunction

  task automatic send(input ldr_pkg::kind_t k, input logic [7:0] c, input logic [6:0] s,
                      input bit known, input logic [14:0] total);
    int          gap;
    logic [14:0] predicted;
    gap = 0;
    if (!steady_stretch) begin
      while ($urandom_range(0, 99) < 36) gap++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_kind  <= k;
    in_count <= c;
    in_sides <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_total(k, c, s);
    total_q.push_back(known ? total : predicted);
  endtask

  task automatic write_seed(input logic [31:0] value);
    start <= 1'b0;
    while (total_q.size() != 0 || busy) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    lcg_q = value;
  endtask

  task automatic run_random(input int n_reqs);
    int unsigned    pick;
    int unsigned    cnt;
    int unsigned    sd;
    ldr_pkg::kind_t k;
    for (int i = 0; i < n_reqs; i++) begin
      k    = ldr_pkg::kind_t'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        cnt = $urandom_range(0, 12);
      end else if (pick < 95) begin
        cnt = $urandom_range(0, 63);
      end else begin
        cnt = $urandom_range(0, 255);
      end
      sd = $urandom_range(0, 127);
      send(k, cnt[7:0], sd[6:0], 1'b0, 15'd0);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (total_q.size() == 0) begin
        $error("unexpected result: out_total %0d with no request pending", out_total);
        fail_count++;
      end else begin
        want_total = total_q.pop_front();
        if (out_total !== want_total) begin
          $error("out_total mismatch: expected %0d, actual %0d", want_total, out_total);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    fail_count     = 0;
    steady_stretch = 1'b0;
    rst_n    <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    start    <= 1'b0;
    in_kind  <= ldr_pkg::KIND_ROLL;
    in_count <= '0;
    in_sides <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    lcg_q       = '0;
    mul_wheel_q = 17'(ldr_pkg::LDR_MULT_WHEEL_RST);
    inc_wheel_q = 17'(ldr_pkg::LDR_INCR_WHEEL_RST);

    foreach (directed_reqs[i]) begin
      send(directed_reqs[i].kind, directed_reqs[i].count, directed_reqs[i].sides,
           directed_reqs[i].known, directed_reqs[i].total);
    end

    write_seed(32'hFFFF_FFFF);
    run_random(160);

    // A single die whose first draw is rejected, then a percentile request of zero.
    write_seed(find_seed(1'b0));
    send(ldr_pkg::KIND_ROLL, 8'd1, 7'd6, 1'b0, 15'd0);
    write_seed(find_seed(1'b1));
    send(ldr_pkg::KIND_PCT, 8'd0, 7'd0, 1'b1, 15'(ldr_pkg::LDR_PCT_ZERO));

    write_seed(32'd0);
    steady_stretch = 1'b1;
    run_random(120);
    steady_stretch = 1'b0;

    write_seed($urandom());
    run_random(200);

    start <= 1'b0;
    while (total_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
